[sv/crc16_frame_deframer_resync_unit_defines.svh]
// Assertion macros shared by the deframer RTL.
// Each macro expects signals named clk and rst_n in the calling scope.
`ifndef CRC16_FRAME_DEFRAMER_RESYNC_UNIT_DEFINES_SVH
`define CRC16_FRAME_DEFRAMER_RESYNC_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define CFDR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("cfdr assertion failed");
`define CFDR_NEVER(lbl, expr) `CFDR_ASSERT(lbl, !(expr))
`else
`define CFDR_ASSERT(lbl, prop)
`define CFDR_NEVER(lbl, expr)
`endif
`endif

[sv/cfdr_pkg.sv]
package cfdr_pkg;

  localparam logic [7:0]  MAGIC_BYTE = 8'hA5;
  localparam int          HDR_LEN    = 1 + 1 + 4 + 4;
  localparam int          CRC_LEN    = 2;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'h1021;
  localparam logic [15:0] CRC_MSB    = 16'h8000;

  typedef struct packed {
    logic [7:0]  frame_type;
    logic [31:0] correlation;
    logic [5:0]  payload_length;
    logic        has_byte;
    logic [7:0]  data_byte;
    logic        frame_end;
    logic        run_end;
  } res_t;

  // CRC-16/CCITT-FALSE, one byte, MSB first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if ((c & CRC_MSB) != 16'h0000) c = (c << 1) ^ CRC_POLY;
      else c = c << 1;
    end
    return c;
  endfunction

endpackage

[sv/cfdr_if.sv]
interface cfdr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface cfdr_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  frame_type;
  logic [31:0] correlation;
  logic [5:0]  payload_length;
  logic        has_byte;
  logic [7:0]  data_byte;
  logic        frame_end;
  logic        run_end;
  modport source (output valid, output frame_type, output correlation, output payload_length,
                  output has_byte, output data_byte, output frame_end, output run_end,
                  input ready);
  modport sink (input valid, input frame_type, input correlation, input payload_length,
                input has_byte, input data_byte, input frame_end, input run_end,
                output ready);
endinterface

[sv/crc16_frame_deframer_resync_unit.sv]
// Length-prefixed frame deframer with CRC-16/CCITT-FALSE check and resync.
// Input channel in_ch carries one received link byte per request. Output
// channel out_ch carries one request per payload byte of each good frame (one
// request with has_byte low for an empty frame), with frame type, correlation
// id and length, frame_end on a frame's last request and run_end on the last
// request caused by one input byte. Both channels use valid/ready handshakes.
// A two-entry input queue lets the link keep sending while the scan engine
// works. Each byte is appended to the store and the buffer is rescanned; a
// candidate start that is not the magic byte is skipped, otherwise its header
// is read and, when the whole frame is buffered, its CRC is checked. Emission
// delivers one result per cycle while the output does not stall. The engine
// reads the byte store through a single read port, one buffered byte per
// cycle during a scan.
// A stalled receiver holds the output register; the engine waits with the
// next result and the input queue fills, after which in_ch.ready drops.
// A synchronous low reset empties the queue, the store and the output
// register; no clearing pass is needed since only written entries are read.
module crc16_frame_deframer_resync_unit #(
  parameter int MAX_PAYLOAD = 32,
  parameter int STORE_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  cfdr_in_if.sink    in_ch,
  cfdr_out_if.source out_ch
);
  import cfdr_pkg::*;

  // Queue handoff between the front and the scan engine.
  logic       q_valid;
  logic [7:0] q_byte;
  logic       q_pop;

  cfdr_front u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
    .q_valid(q_valid), .q_byte(q_byte), .q_pop(q_pop)
  );

  // The engine appends each byte, rescans the buffer and delivers results.
  cfdr_back #(.MAX_PAYLOAD(MAX_PAYLOAD), .STORE_DEPTH(STORE_DEPTH)) u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(q_valid), .q_byte(q_byte), .q_pop(q_pop),
    .out_ch(out_ch)
  );
endmodule

[sv/cfdr_ram.sv]
module cfdr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

[sv/cfdr_front.sv]
// Two-entry byte queue between the link side and the scan engine.
module cfdr_front (
  input  logic       clk,
  input  logic       rst_n,
  cfdr_in_if.sink    in_ch,
  output logic       q_valid,
  output logic [7:0] q_byte,
  input  logic       q_pop
);
  logic [7:0] slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push = in_ch.valid && in_ch.ready;
  assign q_valid = (cnt_r != 2'd0);
  assign pop = q_pop && q_valid;
  assign q_byte = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= in_ch.rx_byte;
  end
endmodule

[sv/cfdr_back.sv]
`include "crc16_frame_deframer_resync_unit_defines.svh"
// Scan engine: appends bytes to the circular store, hunts frames, emits results.
module cfdr_back #(
  parameter int MAX_PAYLOAD = 32,
  parameter int STORE_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  input  logic [7:0] q_byte,
  output logic       q_pop,
  cfdr_out_if.source out_ch
);
  import cfdr_pkg::*;

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int CW = $clog2(STORE_DEPTH + 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_CHK  = 5'b00010,
    S_SCAN = 5'b00100,
    S_EMIT = 5'b01000,
    S_DONE = 5'b10000
  } st_t;

  st_t         st_r, st_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic [5:0]  idx_r, idx_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [31:0] corr_r, corr_nxt;
  logic [23:0] lenb_r, lenb_nxt;
  logic [5:0]  len_r, len_nxt;
  logic [7:0]  want_lo_r, want_lo_nxt;
  logic        pend_v_r, pend_v_nxt;
  res_t        pend_r, pend_nxt;
  logic        out_v_r, out_v_nxt;
  res_t        out_r, out_nxt;

  logic [7:0]  rdata;
  logic [7:0]  rd_rel;
  logic [AW-1:0] rd_addr, wr_addr;
  logic        we;
  logic [7:0]  rel_w, abs_w, wr_w;
  logic [CW-1:0] avail;
  logic [31:0] len32;
  logic [6:0]  need_len;
  logic [6:0]  idx7;
  logic [6:0]  end_crc;
  logic        can_push, take;
  logic [5:0]  nres;
  res_t        new_res;

  function automatic logic [7:0] wrap8(input logic [8:0] s);
    logic [8:0] t;
    t = (s >= 9'(STORE_DEPTH)) ? s - 9'(STORE_DEPTH) : s;
    return t[7:0];
  endfunction

  cfdr_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_store (
    .clk(clk), .we(we), .waddr(wr_addr), .wdata(q_byte), .raddr(rd_addr), .rdata(rdata)
  );

  assign avail    = fill_r - pos_r;
  assign len32    = {rdata, lenb_r};
  assign need_len = 7'(HDR_LEN + CRC_LEN) + 7'(len32[5:0]);
  assign idx7     = 7'(idx_r);
  assign end_crc  = 7'(HDR_LEN) + 7'(len_r);
  assign can_push = !out_v_r || out_ch.ready;
  assign take     = !pend_v_r || can_push;
  assign nres     = (len_r == 6'd0) ? 6'd1 : len_r;
  assign rel_w    = wrap8(9'(pos_r) + 9'(rd_rel));
  assign abs_w    = wrap8(9'(head_r) + 9'(rel_w));
  assign rd_addr  = abs_w[AW-1:0];
  assign wr_w     = wrap8(9'(head_r) + 9'(fill_r));
  assign wr_addr  = wr_w[AW-1:0];
  assign we       = (st_r == S_IDLE) && q_valid;
  assign q_pop    = we;

  always_comb begin
    new_res.frame_type     = type_r;
    new_res.correlation    = corr_r;
    new_res.payload_length = len_r;
    new_res.has_byte       = (len_r != 6'd0);
    new_res.data_byte      = (len_r != 6'd0) ? rdata : 8'h00;
    new_res.frame_end      = (idx_r + 6'd1 == nres);
    new_res.run_end        = 1'b0;
  end

  always_comb begin
    st_nxt = st_r;  head_nxt = head_r;  fill_nxt = fill_r;  pos_nxt = pos_r;
    idx_nxt = idx_r;  crc_nxt = crc_r;  type_nxt = type_r;  corr_nxt = corr_r;
    lenb_nxt = lenb_r;  len_nxt = len_r;  want_lo_nxt = want_lo_r;
    pend_v_nxt = pend_v_r;  pend_nxt = pend_r;
    out_v_nxt = out_v_r && !out_ch.ready;  out_nxt = out_r;
    rd_rel = 8'd0;
    case (st_r)
      S_IDLE: begin
        if (q_valid) begin
          if (fill_r == CW'(STORE_DEPTH)) begin
            head_nxt = AW'(wrap8(9'(head_r) + 9'd1));
          end else begin
            fill_nxt = fill_r + CW'(1);
          end
          pos_nxt = '0;
          st_nxt = S_CHK;
        end
      end
      S_CHK: begin
        rd_rel = 8'd0;
        if (avail >= CW'(HDR_LEN)) begin
          idx_nxt = 6'd0;
          crc_nxt = CRC_INIT;
          st_nxt = S_SCAN;
        end else begin
          st_nxt = S_DONE;
        end
      end
      S_SCAN: begin
        rd_rel = (idx_r >= 6'(HDR_LEN) && idx7 == end_crc + 7'd1) ? 8'(HDR_LEN)
                                                                  : 8'(idx_r) + 8'd1;
        idx_nxt = idx_r + 6'd1;
        if (idx_r < 6'(HDR_LEN) || idx7 < end_crc) crc_nxt = crc_byte(crc_r, rdata);
        case (idx_r)
          6'd0: if (rdata != MAGIC_BYTE) begin
            pos_nxt = pos_r + CW'(1);
            st_nxt = S_CHK;
          end
          6'd1: type_nxt = rdata;
          6'd2: corr_nxt[7:0] = rdata;
          6'd3: corr_nxt[15:8] = rdata;
          6'd4: corr_nxt[23:16] = rdata;
          6'd5: corr_nxt[31:24] = rdata;
          6'd6: lenb_nxt[7:0] = rdata;
          6'd7: lenb_nxt[15:8] = rdata;
          6'd8: lenb_nxt[23:16] = rdata;
          6'd9: begin
            len_nxt = len32[5:0];
            if (len32 > 32'(MAX_PAYLOAD)) begin
              pos_nxt = pos_r + CW'(1);
              st_nxt = S_CHK;
            end else if (7'(avail) < need_len) begin
              st_nxt = S_DONE;
            end
          end
          default: begin
            if (idx7 == end_crc) want_lo_nxt = rdata;
            if (idx7 == end_crc + 7'd1) begin
              idx_nxt = 6'd0;
              if ({rdata, want_lo_r} == crc_r) begin
                st_nxt = S_EMIT;
              end else begin
                pos_nxt = pos_r + CW'(1);
                st_nxt = S_CHK;
              end
            end
          end
        endcase
      end
      S_EMIT: begin
        rd_rel = 8'(HDR_LEN) + 8'(idx_r) + 8'(take);
        if (take) begin
          if (pend_v_r) begin
            out_v_nxt = 1'b1;
            out_nxt = pend_r;
          end
          pend_v_nxt = 1'b1;
          pend_nxt = new_res;
          idx_nxt = idx_r + 6'd1;
          if (new_res.frame_end) begin
            pos_nxt = pos_r + CW'(end_crc + 7'(CRC_LEN));
            st_nxt = S_CHK;
          end
        end
      end
      S_DONE: begin
        if (!pend_v_r || can_push) begin
          if (pend_v_r) begin
            out_v_nxt = 1'b1;
            out_nxt = pend_r;
            out_nxt.run_end = 1'b1;
          end
          pend_v_nxt = 1'b0;
          head_nxt = AW'(wrap8(9'(head_r) + 9'(pos_r)));
          fill_nxt = fill_r - pos_r;
          pos_nxt = '0;
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_IDLE;
      head_r   <= '0;
      fill_r   <= '0;
      pos_r    <= '0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      head_r   <= head_nxt;
      fill_r   <= fill_nxt;
      pos_r    <= pos_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;  crc_r <= crc_nxt;  type_r <= type_nxt;  corr_r <= corr_nxt;
    lenb_r <= lenb_nxt;  len_r <= len_nxt;  want_lo_r <= want_lo_nxt;
    pend_r <= pend_nxt;  out_r <= out_nxt;
  end

  assign out_ch.valid          = out_v_r;
  assign out_ch.frame_type     = out_r.frame_type;
  assign out_ch.correlation    = out_r.correlation;
  assign out_ch.payload_length = out_r.payload_length;
  assign out_ch.has_byte       = out_r.has_byte;
  assign out_ch.data_byte      = out_r.data_byte;
  assign out_ch.frame_end      = out_r.frame_end;
  assign out_ch.run_end        = out_r.run_end;

  `CFDR_NEVER(a_fill_le_depth, fill_r > CW'(STORE_DEPTH))
  `CFDR_NEVER(a_pos_le_fill, pos_r > fill_r)
  `CFDR_NEVER(a_idle_no_pending, st_r == S_IDLE && pend_v_r)
  `CFDR_ASSERT(a_emit_len_ok, st_r == S_EMIT |-> len_r <= 6'(MAX_PAYLOAD))
endmodule
